>>> design/i2c_register_access_master_defines.svh
// Assertion macros for the I2C register access master.
// Depends on nothing; the including module must declare clk_i and rst_ni.
`ifndef I2C_REGISTER_ACCESS_MASTER_DEFINES_SVH
`define I2C_REGISTER_ACCESS_MASTER_DEFINES_SVH

// Clocked property check, disabled while reset is asserted.
`define I2CRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define I2CRA_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

>>> design/i2cra_pkg.sv
// Package for the I2C register access master: phase encoding and constants.
// Depends on nothing.
package i2cra_pkg;

  // Transaction phases, one-hot.
  typedef enum logic [14:0] {
    PH_IDLE      = 15'b000000000000001,
    PH_START     = 15'b000000000000010,
    PH_RESTART   = 15'b000000000000100,
    PH_SEND_AW   = 15'b000000000001000,
    PH_ACK_AW    = 15'b000000000010000,
    PH_SEND_REG  = 15'b000000000100000,
    PH_ACK_REG   = 15'b000000001000000,
    PH_SEND_DATA = 15'b000000010000000,
    PH_ACK_DATA  = 15'b000000100000000,
    PH_SEND_AR   = 15'b000001000000000,
    PH_ACK_AR    = 15'b000010000000000,
    PH_READ      = 15'b000100000000000,
    PH_ACK_OUT   = 15'b001000000000000,
    PH_STOP      = 15'b010000000000000,
    PH_STOP_FAIL = 15'b100000000000000
  } phase_e;

  localparam int unsigned MAX_BYTES = 256;

  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd100;
  localparam logic [7:0] WAIT_MAX        = 8'hFF;
  localparam logic [1:0] LAST_QUARTER    = 2'd3;
  localparam logic [2:0] LAST_BIT        = 3'd7;
  localparam logic       RW_WRITE        = 1'b0;
  localparam logic       RW_READ         = 1'b1;

endpackage

>>> design/i2c_register_access_master.sv
// I2C register access master: one quarter-bit tick per input beat.
// Latency: the result beat for a tick is valid on the cycle after the tick is accepted.
// Throughput: one tick per cycle while the result side takes each beat; the single result register
//   accepts a new tick in the same cycle that its held beat is taken.
// Reset (async, active low): idle phase, empty result register, ack_timeout = 100.
// Depends on i2cra_pkg and i2c_register_access_master_defines.svh.
`include "i2c_register_access_master_defines.svh"

module i2c_register_access_master #(
  parameter int unsigned MaxBytes = i2cra_pkg::MAX_BYTES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration write port.
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  // Tick input channel.
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       sda_in_i,
  input  logic       go_i,
  input  logic       is_read_i,
  input  logic [6:0] device_addr_i,
  input  logic [7:0] sub_addr_i,
  input  logic [8:0] byte_count_i,
  input  logic [7:0] write_data_i,
  // Result channel.
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       scl_o,
  output logic       sda_out_o,
  output logic       busy_res_o,
  output logic       write_taken_o,
  output logic       read_valid_o,
  output logic [7:0] read_data_o,
  output logic       done_res_o,
  output logic       failed_o
);
  import i2cra_pkg::*;

  localparam int unsigned BlW  = $clog2(MaxBytes + 1);
  localparam int unsigned CmpW = (BlW > 9) ? BlW : 9;

  // Transaction state.
  phase_e           phase_q, phase_d;
  logic [1:0]       quarter_q, quarter_d;
  logic [2:0]       bit_q, bit_d;
  logic [7:0]       shift_q, shift_d;
  logic [BlW-1:0]   bytes_left_q, bytes_left_d;
  logic [7:0]       wait_q, wait_d;
  logic [6:0]       dev_q, dev_d;
  logic [7:0]       reg_q, reg_d;
  logic             dir_q, dir_d;
  logic [7:0]       ack_timeout_q;

  // Result register.
  logic             out_valid_q, out_valid_d;
  logic             scl_q, sda_q, busy_q, taken_q, rvalid_q, done_q, fail_q;
  logic [7:0]       rdata_q;

  // Per-tick results before registering.
  logic             scl_n, sda_n, taken_n, rvalid_n, done_n, fail_n;
  logic [7:0]       rdata_n;
  logic             last_q;
  logic [7:0]       wait_inc;
  logic [7:0]       shift_in;
  logic [CmpW-1:0]  count_ext;

  logic             in_fire;

  // The result register frees up in the same cycle its beat is taken.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign last_q    = (quarter_q == LAST_QUARTER);
  assign wait_inc  = (wait_q < WAIT_MAX) ? wait_q + 8'd1 : wait_q;
  assign shift_in  = {shift_q[6:0], sda_in_i};
  assign count_ext = CmpW'(byte_count_i);

  // Phase sequencer: next state and event pulses for one tick.
  always_comb begin
    phase_d      = phase_q;
    quarter_d    = quarter_q;
    bit_d        = bit_q;
    shift_d      = shift_q;
    bytes_left_d = bytes_left_q;
    wait_d       = wait_q;
    dev_d        = dev_q;
    reg_d        = reg_q;
    dir_d        = dir_q;
    taken_n      = 1'b0;
    rvalid_n     = 1'b0;
    rdata_n      = 8'd0;
    done_n       = 1'b0;
    fail_n       = 1'b0;

    case (phase_q)
      PH_IDLE: begin
        if (go_i) begin
          dir_d = is_read_i;
          dev_d = device_addr_i;
          reg_d = sub_addr_i;
          // Requests above the capacity are clipped to it.
          if (count_ext > CmpW'(MaxBytes)) begin
            bytes_left_d = BlW'(MaxBytes);
          end else begin
            bytes_left_d = BlW'(byte_count_i);
          end
          phase_d   = PH_START;
          quarter_d = 2'd0;
        end
      end

      PH_START, PH_RESTART: begin
        if (!last_q) begin
          quarter_d = quarter_q + 2'd1;
        end else begin
          bit_d     = 3'd0;
          quarter_d = 2'd0;
          if (phase_q == PH_START) begin
            shift_d = {dev_q, RW_WRITE};
            phase_d = PH_SEND_AW;
          end else begin
            shift_d = {dev_q, RW_READ};
            phase_d = PH_SEND_AR;
          end
        end
      end

      PH_SEND_AW, PH_SEND_REG, PH_SEND_DATA, PH_SEND_AR: begin
        if (!last_q) begin
          quarter_d = quarter_q + 2'd1;
        end else if (bit_q == LAST_BIT) begin
          wait_d    = 8'd0;
          quarter_d = 2'd0;
          case (phase_q)
            PH_SEND_AW:   phase_d = PH_ACK_AW;
            PH_SEND_REG:  phase_d = PH_ACK_REG;
            PH_SEND_DATA: phase_d = PH_ACK_DATA;
            default:      phase_d = PH_ACK_AR;
          endcase
        end else begin
          bit_d     = bit_q + 3'd1;
          shift_d   = {shift_q[6:0], 1'b0};
          quarter_d = 2'd0;
        end
      end

      PH_ACK_AW, PH_ACK_REG, PH_ACK_DATA, PH_ACK_AR: begin
        if (!last_q) begin
          quarter_d = quarter_q + 2'd1;
        end else if (!sda_in_i) begin
          // Slave acknowledged: the next slot starts on this tick.
          quarter_d = 2'd0;
          if (phase_q == PH_ACK_AW) begin
            shift_d = reg_q;
            bit_d   = 3'd0;
            phase_d = PH_SEND_REG;
          end else if (phase_q == PH_ACK_REG && dir_q) begin
            phase_d = PH_RESTART;
          end else if (phase_q == PH_ACK_AR) begin
            if (bytes_left_q != '0) begin
              shift_d = 8'd0;
              bit_d   = 3'd0;
              phase_d = PH_READ;
            end else begin
              phase_d = PH_STOP;
            end
          end else begin
            if (bytes_left_q != '0) begin
              bytes_left_d = bytes_left_q - BlW'(1);
              taken_n      = 1'b1;
              shift_d      = write_data_i;
              bit_d        = 3'd0;
              phase_d      = PH_SEND_DATA;
            end else begin
              phase_d = PH_STOP;
            end
          end
        end else begin
          // Keep polling with SCL high until the timeout runs out.
          wait_d = wait_inc;
          if (wait_inc >= ack_timeout_q) begin
            phase_d   = PH_STOP_FAIL;
            quarter_d = 2'd0;
          end
        end
      end

      PH_READ: begin
        if (!last_q) begin
          quarter_d = quarter_q + 2'd1;
        end else begin
          shift_d   = shift_in;
          quarter_d = 2'd0;
          if (bit_q == LAST_BIT) begin
            rvalid_n = 1'b1;
            rdata_n  = shift_in;
            if (bytes_left_q != '0) begin
              bytes_left_d = bytes_left_q - BlW'(1);
            end
            phase_d = PH_ACK_OUT;
          end else begin
            bit_d = bit_q + 3'd1;
          end
        end
      end

      PH_ACK_OUT: begin
        if (!last_q) begin
          quarter_d = quarter_q + 2'd1;
        end else begin
          quarter_d = 2'd0;
          if (bytes_left_q != '0) begin
            shift_d = 8'd0;
            bit_d   = 3'd0;
            phase_d = PH_READ;
          end else begin
            phase_d = PH_STOP;
          end
        end
      end

      PH_STOP, PH_STOP_FAIL: begin
        if (!last_q) begin
          quarter_d = quarter_q + 2'd1;
        end else begin
          done_n    = 1'b1;
          fail_n    = (phase_q == PH_STOP_FAIL);
          phase_d   = PH_IDLE;
          quarter_d = 2'd0;
        end
      end

      default: begin
        phase_d   = PH_IDLE;
        quarter_d = 2'd0;
      end
    endcase
  end

  // Bus levels follow the state after this tick.
  always_comb begin
    case (phase_d)
      PH_START, PH_RESTART: begin
        if (quarter_d == 2'd0) begin
          scl_n = (phase_d == PH_START);
        end else begin
          scl_n = (quarter_d != LAST_QUARTER);
        end
        sda_n = !quarter_d[1];
      end
      PH_SEND_AW, PH_SEND_REG, PH_SEND_DATA, PH_SEND_AR: begin
        scl_n = quarter_d[1];
        sda_n = shift_d[7];
      end
      PH_ACK_OUT: begin
        // ACK after every byte but the last, which gets NACK.
        scl_n = quarter_d[1];
        sda_n = (bytes_left_d == '0);
      end
      PH_STOP, PH_STOP_FAIL: begin
        scl_n = quarter_d[1];
        sda_n = (quarter_d == 2'd0) || (quarter_d == LAST_QUARTER);
      end
      PH_IDLE: begin
        scl_n = 1'b1;
        sda_n = 1'b1;
      end
      default: begin
        scl_n = quarter_d[1];
        sda_n = 1'b1;
      end
    endcase
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_timeout_q <= ACK_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      ack_timeout_q <= cfg_wdata_i;
    end
  end

  // Transaction state advances once per accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      quarter_q    <= 2'd0;
      bit_q        <= 3'd0;
      shift_q      <= 8'd0;
      bytes_left_q <= '0;
      wait_q       <= 8'd0;
      dev_q        <= 7'd0;
      reg_q        <= 8'd0;
      dir_q        <= 1'b0;
    end else if (in_fire) begin
      phase_q      <= phase_d;
      quarter_q    <= quarter_d;
      bit_q        <= bit_d;
      shift_q      <= shift_d;
      bytes_left_q <= bytes_left_d;
      wait_q       <= wait_d;
      dev_q        <= dev_d;
      reg_q        <= reg_d;
      dir_q        <= dir_d;
    end
  end

  // Result register valid flag.
  always_comb begin
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, loaded with each accepted tick.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      scl_q    <= scl_n;
      sda_q    <= sda_n;
      busy_q   <= (phase_d != PH_IDLE);
      taken_q  <= taken_n;
      rvalid_q <= rvalid_n;
      rdata_q  <= rdata_n;
      done_q   <= done_n;
      fail_q   <= fail_n;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign scl_o         = scl_q;
  assign sda_out_o     = sda_q;
  assign busy_res_o    = busy_q;
  assign write_taken_o = taken_q;
  assign read_valid_o  = rvalid_q;
  assign read_data_o   = rdata_q;
  assign done_res_o    = done_q;
  assign failed_o      = fail_q;

  // Checks on the sequencer and the result register.
  `I2CRA_ASSERT(a_fail_with_done, out_valid_q && fail_q |-> done_q, "failed without done")
  `I2CRA_ASSERT_NEVER(a_taken_and_read, out_valid_q && taken_q && rvalid_q, "taken with rvalid")
  `I2CRA_ASSERT(a_idle_quiet, in_fire && phase_q == PH_IDLE |=> !taken_q && !rvalid_q, "idle pulse")
  `I2CRA_ASSERT_NEVER(a_stall_accept, out_valid_q && !out_ready_i && in_fire, "beat overwritten")
  `I2CRA_ASSERT(a_bytes_bound, 1'b1 |-> bytes_left_q <= BlW'(MaxBytes), "count over cap")

endmodule

>>> test/i2c_register_access_master_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for i2c_register_access_master: ticks are driven with a small
// slave model that answers SDA, and every result beat is checked by a scoreboard.
// Depends on i2cra_pkg and the i2c_register_access_master RTL.
module i2c_register_access_master_test;
  import i2cra_pkg::*;

  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned RANDOM_TICKS    = 240;
  localparam int unsigned REPORT_LIMIT    = 10;
  localparam int unsigned COUNT_CAP       = MAX_BYTES;
  localparam bit [7:0]    RESET_ACK_LIMIT = 8'd100;

  // One input beat: a quarter-bit tick.
  typedef struct packed {
    logic       sda;
    logic       go;
    logic       is_read;
    logic [6:0] dev;
    logic [7:0] sub_addr;
    logic [8:0] count;
    logic [7:0] wdata;
  } tick_t;

  // One result beat: bus drive levels and status pulses.
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       taken;
    logic       rvalid;
    logic [7:0] rdata;
    logic       done;
    logic       failed;
  } beat_t;

  // Tracks the master's bus state per tick and holds the result beats still to come.
  class i2c_master_scoreboard;
    phase_e      ph;
    bit [1:0]    qstep;
    bit [2:0]    bitno;
    bit [7:0]    shreg;
    bit [8:0]    left;
    bit [7:0]    polls;
    bit [6:0]    dev;
    bit [7:0]    regno;
    bit          rd;
    bit [7:0]    ack_limit;
    beat_t       expected_beats[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned ticks;
    int unsigned dones;
    int unsigned aborts;
    int unsigned bytes_read;
    int unsigned bytes_written;

    function new();
      ph        = PH_IDLE;
      ack_limit = RESET_ACK_LIMIT;
    endfunction

    function void enter(phase_e p);
      ph    = p;
      qstep = 2'd0;
    endfunction

    function void load_byte(phase_e p, bit [7:0] b);
      shreg = b;
      bitno = 3'd0;
      enter(p);
    endfunction

    // Takes the next write byte if any remain; returns whether one was taken.
    function bit next_write(bit [7:0] wd);
      if (left != 0) begin
        left--;
        load_byte(PH_SEND_DATA, wd);
        return 1'b1;
      end
      enter(PH_STOP);
      return 1'b0;
    endfunction

    function void next_read();
      if (left != 0) begin
        load_byte(PH_READ, 8'h00);
      end else begin
        enter(PH_STOP);
      end
    endfunction

    // Advances the master by one tick and returns the beat it should produce.
    function beat_t advance_master(tick_t t);
      beat_t r;
      bit    last;
      r    = '0;
      last = (qstep == 2'd3);
      case (ph)
        PH_IDLE: begin
          if (t.go) begin
            rd    = t.is_read;
            dev   = t.dev;
            regno = t.sub_addr;
            left  = (t.count > COUNT_CAP) ? 9'(COUNT_CAP) : t.count;
            enter(PH_START);
          end
        end
        PH_START, PH_RESTART: begin
          if (!last) qstep++;
          else if (ph == PH_START) load_byte(PH_SEND_AW, {dev, 1'b0});
          else load_byte(PH_SEND_AR, {dev, 1'b1});
        end
        PH_SEND_AW, PH_SEND_REG, PH_SEND_DATA, PH_SEND_AR: begin
          if (!last) begin
            qstep++;
          end else if (bitno == 3'd7) begin
            polls = 8'd0;
            case (ph)
              PH_SEND_AW:   enter(PH_ACK_AW);
              PH_SEND_REG:  enter(PH_ACK_REG);
              PH_SEND_DATA: enter(PH_ACK_DATA);
              default:      enter(PH_ACK_AR);
            endcase
          end else begin
            bitno++;
            shreg = shreg << 1;
            qstep = 2'd0;
          end
        end
        PH_ACK_AW, PH_ACK_REG, PH_ACK_DATA, PH_ACK_AR: begin
          if (!last) begin
            qstep++;
          end else if (!t.sda) begin
            case (ph)
              PH_ACK_AW: load_byte(PH_SEND_REG, regno);
              PH_ACK_AR: next_read();
              PH_ACK_REG: begin
                if (rd) enter(PH_RESTART);
                else r.taken = next_write(t.wdata);
              end
              default: r.taken = next_write(t.wdata);
            endcase
          end else begin
            // No acknowledge on this poll; give up once the limit is reached.
            if (polls != 8'hFF) polls++;
            if (polls >= ack_limit) enter(PH_STOP_FAIL);
          end
        end
        PH_READ: begin
          if (!last) begin
            qstep++;
          end else begin
            shreg = {shreg[6:0], t.sda};
            if (bitno == 3'd7) begin
              r.rvalid = 1'b1;
              r.rdata  = shreg;
              if (left != 0) left--;
              enter(PH_ACK_OUT);
            end else begin
              bitno++;
              qstep = 2'd0;
            end
          end
        end
        PH_ACK_OUT: begin
          if (!last) qstep++;
          else next_read();
        end
        PH_STOP, PH_STOP_FAIL: begin
          if (!last) begin
            qstep++;
          end else begin
            r.done   = 1'b1;
            r.failed = (ph == PH_STOP_FAIL);
            enter(PH_IDLE);
          end
        end
        default: enter(PH_IDLE);
      endcase

      // Drive levels follow the state after this tick.
      r.busy = (ph != PH_IDLE);
      r.scl  = qstep[1];
      r.sda  = 1'b1;
      case (ph)
        PH_IDLE: r.scl = 1'b1;
        PH_START, PH_RESTART: begin
          r.scl = (qstep == 2'd0) ? (ph == PH_START) : (qstep != 2'd3);
          r.sda = (qstep < 2'd2);
        end
        PH_SEND_AW, PH_SEND_REG, PH_SEND_DATA, PH_SEND_AR: r.sda = shreg[7];
        PH_ACK_OUT: r.sda = (left == 0);
        PH_STOP, PH_STOP_FAIL: r.sda = (qstep == 2'd0) || (qstep == 2'd3);
        default: ;
      endcase
      return r;
    endfunction

    function void note_tick(tick_t t);
      beat_t b;
      b = advance_master(t);
      expected_beats.push_back(b);
      ticks++;
      if (b.done) dones++;
      if (b.failed) aborts++;
      if (b.rvalid) bytes_read++;
      if (b.taken) bytes_written++;
    endfunction

    function string show_beat(beat_t b);
      return $sformatf({"scl=%0b sda=%0b busy=%0b taken=%0b rvalid=%0b rdata=%02h ",
                        "done=%0b fail=%0b"},
                       b.scl, b.sda, b.busy, b.taken, b.rvalid, b.rdata, b.done, b.failed);
    endfunction

    function void check_result(beat_t got);
      beat_t want;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result beat with nothing expected: %s", $time, show_beat(got));
        return;
      end
      want = expected_beats.pop_front();
      checked++;
      if (got.scl !== want.scl || got.sda !== want.sda || got.busy !== want.busy ||
          got.taken !== want.taken || got.rvalid !== want.rvalid ||
          got.rdata !== want.rdata || got.done !== want.done || got.failed !== want.failed) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: result beat %0d differs", $time, checked);
          $display("  expected %s", show_beat(want));
          $display("  actual   %s", show_beat(got));
        end
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni        = 1'b0;
  logic       cfg_we_i      = 1'b0;
  logic [7:0] cfg_wdata_i   = 8'h00;
  logic       in_valid_i    = 1'b0;
  logic       in_ready_o;
  logic       sda_in_i      = 1'b1;
  logic       go_i          = 1'b0;
  logic       is_read_i     = 1'b0;
  logic [6:0] device_addr_i = 7'h00;
  logic [7:0] sub_addr_i    = 8'h00;
  logic [8:0] byte_count_i  = 9'h000;
  logic [7:0] write_data_i  = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i   = 1'b0;
  logic       scl_o;
  logic       sda_out_o;
  logic       busy_res_o;
  logic       write_taken_o;
  logic       read_valid_o;
  logic [7:0] read_data_o;
  logic       done_res_o;
  logic       failed_o;

  i2c_master_scoreboard sb;

  // Slave behavior for the current transfer: an acknowledge phase it never answers
  // (PH_IDLE for none) and a percentage of polls it lets pass without answering.
  phase_e      refuse_ph  = PH_IDLE;
  int unsigned nack_pct   = 0;
  int unsigned calm_ticks = 0;
  bit          quiet_end  = 1'b0;

  i2c_register_access_master uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sda_in_i     (sda_in_i),
    .go_i         (go_i),
    .is_read_i    (is_read_i),
    .device_addr_i(device_addr_i),
    .sub_addr_i   (sub_addr_i),
    .byte_count_i (byte_count_i),
    .write_data_i (write_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .scl_o        (scl_o),
    .sda_out_o    (sda_out_o),
    .busy_res_o   (busy_res_o),
    .write_taken_o(write_taken_o),
    .read_valid_o (read_valid_o),
    .read_data_o  (read_data_o),
    .done_res_o   (done_res_o),
    .failed_o     (failed_o)
  );

  // Free-running clock, 10 ns period.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offers one tick and holds it until the block takes the beat.
  task automatic send_tick(input tick_t t);
    in_valid_i    <= 1'b1;
    sda_in_i      <= t.sda;
    go_i          <= t.go;
    is_read_i     <= t.is_read;
    device_addr_i <= t.dev;
    sub_addr_i    <= t.sub_addr;
    byte_count_i  <= t.count;
    write_data_i  <= t.wdata;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_tick(t);
  endtask

  task automatic sender_gap(input int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Random sender idling, with calm stretches and none at all near the end.
  task automatic maybe_gap();
    if (quiet_end) return;
    if (calm_ticks != 0) begin
      calm_ticks--;
      return;
    end
    case ($urandom_range(39))
      0: calm_ticks = $urandom_range(200, 40);
      1, 2: sender_gap($urandom_range(15, 1));
      default: ;
    endcase
  endtask

  // Builds the next tick: the slave answers acknowledge polls, other SDA samples are random.
  function automatic tick_t slave_tick();
    tick_t t;
    t.go       = ($urandom_range(7) == 0);
    t.is_read  = 1'($urandom_range(1));
    t.dev      = 7'($urandom_range(127));
    t.sub_addr = 8'($urandom_range(255));
    t.count    = 9'($urandom_range(511));
    t.wdata    = 8'($urandom_range(255));
    if (sb.qstep == 2'd3 && sb.ph inside {PH_ACK_AW, PH_ACK_REG, PH_ACK_DATA, PH_ACK_AR})
      t.sda = (sb.ph == refuse_ph) || ($urandom_range(99) < nack_pct);
    else
      t.sda = 1'($urandom_range(1));
    return t;
  endfunction

  // Runs one transfer from go until the master is idle again.
  task automatic run_transfer(input bit rd, input bit [6:0] dev, input bit [7:0] regno,
                              input bit [8:0] count, input phase_e refuse,
                              input int unsigned pct);
    tick_t t;
    refuse_ph = refuse;
    nack_pct  = pct;
    t          = slave_tick();
    t.go       = 1'b1;
    t.is_read  = rd;
    t.dev      = dev;
    t.sub_addr = regno;
    t.count    = count;
    send_tick(t);
    while (sb.ph != PH_IDLE) begin
      maybe_gap();
      send_tick(slave_tick());
    end
  endtask

  // Stops offering and waits until every expected beat has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.expected_beats.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_ack_limit(input bit [7:0] v);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    sb.ack_limit = v;
  endtask

  // Result side: checks each accepted beat and stalls in random bursts, once for a long time.
  initial begin
    int unsigned stall_left;
    int unsigned calm_left;
    int unsigned hold_left;
    bit          held_once;
    beat_t       got;
    stall_left = 0;
    calm_left  = 0;
    hold_left  = 0;
    held_once  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got = '{scl_o, sda_out_o, busy_res_o, write_taken_o, read_valid_o, read_data_o,
                done_res_o, failed_o};
        sb.check_result(got);
      end
      if (hold_left != 0) begin
        hold_left--;
      end else if (!held_once && sb.checked >= 400) begin
        held_once = 1'b1;
        hold_left = 120;
      end else if (stall_left != 0) begin
        stall_left--;
      end else if (calm_left != 0) begin
        calm_left--;
      end else if (!quiet_end) begin
        case ($urandom_range(31))
          0: calm_left = $urandom_range(200, 30);
          1, 2: stall_left = $urandom_range(15, 1);
          default: ;
        endcase
      end
      out_ready_i <= (hold_left == 0) && (stall_left == 0);
    end
  end

  // Watchdog: ends the run when no beat moves on either side for too long.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("i2c_register_access_master_test failed");
    $finish;
  end

  // Main sequence: reset, directed transfers, then random transfers over several limits.
  initial begin
    tick_t       t;
    int unsigned seg;
    int unsigned seg_start;
    int unsigned pick;
    int unsigned pct;
    bit [8:0]    count;
    phase_e      refuse;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // No slave answers at all, so the reset poll limit decides when the write aborts.
    run_transfer(1'b0, 7'h7F, 8'hFF, 9'd1, PH_IDLE, 100);
    // Zero-byte write and read, then short ordinary transfers.
    run_transfer(1'b0, 7'h00, 8'h00, 9'd0, PH_IDLE, 0);
    run_transfer(1'b1, 7'h55, 8'hAA, 9'd0, PH_IDLE, 0);
    run_transfer(1'b0, 7'h2A, 8'h55, 9'd1, PH_IDLE, 0);
    run_transfer(1'b1, 7'h7F, 8'h00, 9'd1, PH_IDLE, 0);

    // A zero limit still allows a single poll.
    write_ack_limit(8'd0);
    run_transfer(1'b1, 7'h11, 8'h3C, 9'd2, PH_ACK_REG, 0);
    run_transfer(1'b0, 7'h22, 8'hC3, 9'd2, PH_IDLE, 50);

    // Longest wait: the address acknowledge never comes.
    write_ack_limit(8'd255);
    run_transfer(1'b0, 7'h33, 8'h0F, 9'd2, PH_ACK_AW, 0);
    run_transfer(1'b1, 7'h44, 8'hF0, 9'd1, PH_IDLE, 70);

    write_ack_limit(8'd1);
    run_transfer(1'b1, 7'h5A, 8'h5A, 9'd3, PH_ACK_AR, 0);

    // Byte count above the cap takes the clipping path; the slave then refuses the data.
    write_ack_limit(8'd3);
    run_transfer(1'b0, 7'h01, 8'h80, 9'h1FF, PH_ACK_DATA, 0);

    // Random transfers in four parts, each with its own poll limit.
    for (seg = 0; seg < 4; seg++) begin
      case (seg)
        0: write_ack_limit(8'($urandom_range(12, 1)));
        1: write_ack_limit(8'($urandom_range(255)));
        2: write_ack_limit(8'($urandom_range(4, 1)));
        default: write_ack_limit(8'($urandom_range(40, 2)));
      endcase
      quiet_end = (seg == 3);
      seg_start = sb.ticks;
      while (sb.ticks - seg_start < RANDOM_TICKS / 4) begin
        // A few ticks with no request between transfers.
        repeat ($urandom_range(3)) begin
          t    = slave_tick();
          t.go = 1'b0;
          maybe_gap();
          send_tick(t);
        end
        pick = $urandom_range(99);
        if (pick < 10) count = 9'd0;
        else if (pick < 85) count = 9'($urandom_range(4, 1));
        else count = 9'($urandom_range(8, 5));
        pick = $urandom_range(99);
        pct  = (pick < 60) ? 0 : (pick < 90) ? $urandom_range(60, 10) : 90;
        case ($urandom_range(19))
          0: refuse = PH_ACK_AW;
          1: refuse = PH_ACK_REG;
          2: refuse = PH_ACK_DATA;
          3: refuse = PH_ACK_AR;
          default: refuse = PH_IDLE;
        endcase
        run_transfer(1'($urandom_range(1)), 7'($urandom_range(127)),
                     8'($urandom_range(255)), count, refuse, pct);
      end
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    $display("Run covered %0d ticks and %0d checked beats over %0d transfers, %0d aborted.",
             sb.ticks, sb.checked, sb.dones, sb.aborts);
    $display("The bus carried %0d written and %0d read data bytes.",
             sb.bytes_written, sb.bytes_read);
    if (sb.mismatches == 0 && sb.expected_beats.size() == 0) begin
      $display("i2c_register_access_master_test passed");
    end else begin
      $display("i2c_register_access_master_test failed");
    end
    $finish;
  end

endmodule
